[hw/rtl/sorted_min_priority_queue_unit_macros.svh]
// ---------------------------------------------------------------------------
// sorted min-priority queue assertion macros
// clocked assertion helpers used by the queue unit rtl
// ---------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define SMPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SMPQ_ASSERT_ALWAYS(lbl, cond, msg)
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/smpq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_pkg
// shared constants and types of the sorted min-priority queue
// ---------------------------------------------------------------------------
package smpq_pkg;

  // queue depth and field widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int WT_W     = 32;
  localparam int OCC_W    = 7;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // one stored word
  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic signed [WT_W-1:0] weight;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_cmd_t;

endpackage

[hw/rtl/sorted_min_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_min_priority_queue_unit
// min-priority queue built as a row of sorted shift cells
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one word: operation, item id and
//   signed weight. insert places the item in weight order, remove pops the
//   lightest item.
//   result channel (out_valid/out_ready) gives one word per input word:
//   status, removed id and weight (zero unless removed) and occupancy.
//   the result is registered on the clock edge that takes the input.
//   throughput: one word per cycle while out_ready is high; every cell
//   compares its word with the incoming weight and all cells move in parallel, so nothing iterates.
//   the result register frees itself in the cycle it is taken, so a new
//   word is accepted while out_ready is high even with a result pending.
//   when the receiver stalls, the result holds and in_ready drops until the
//   result is taken.
//   reset clears the item count and the result valid; cell contents are not
//   cleared, since only slots below the count are ever looked at.
//   insert into a full queue drops the item with status full; remove from
//   an empty queue reports status empty.
// ---------------------------------------------------------------------------
`include "sorted_min_priority_queue_unit_macros.svh"

module sorted_min_priority_queue_unit
  import smpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [ID_W-1:0]        in_item_id,
  input  logic signed [WT_W-1:0] in_item_weight,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [ID_W-1:0]        out_id,
  output logic signed [WT_W-1:0] out_weight,
  output logic [OCC_W-1:0]       out_occupancy
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  status_t          status_r;
  entry_t           result_r;
  logic [CNT_W-1:0] occ_r;

  logic      accept;
  logic      is_remove;
  logic      full;
  logic      empty;
  cell_cmd_t cmd;
  entry_t    new_entry;
  status_t   status_nxt;
  entry_t    result_nxt;

  entry_t [CAPACITY-1:0] cell_entry;
  logic   [CAPACITY-1:0] cell_flag;

  // handshake and command decode
  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign is_remove  = (in_operation == OP_REMOVE);
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign empty      = (count_r == '0);
  assign cmd.insert = accept && !is_remove && !full;
  assign cmd.remove = accept && is_remove && !empty;
  assign new_entry  = '{id: in_item_id, weight: in_item_weight};

  // chain of cells, head at index 0
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t prev_e;
    logic   prev_f;
    entry_t next_e;

    if (k == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_f = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[k-1];
      assign prev_f = cell_flag[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cell_entry[k+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .is_head    (k == 0),
      .occupied   (count_r > CNT_W'(k)),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_flag  (prev_f),
      .next_entry (next_e),
      .entry      (cell_entry[k]),
      .flag       (cell_flag[k])
    );
  end

  // result word and next count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    result_nxt = '0;
    if (is_remove) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_REMOVED;
        result_nxt = cell_entry[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      status_r <= status_nxt;
      result_r <= result_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_id        = result_r.id;
  assign out_weight    = result_r.weight;
  assign out_occupancy = OCC_W'(occ_r);

  // checks
  `SMPQ_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `SMPQ_ASSERT_NEXT(a_insert_grows, cmd.insert, count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `SMPQ_ASSERT_NEXT(a_remove_shrinks, cmd.remove, count_r == $past(count_r) - CNT_W'(1), "remove did not shrink count")
  `SMPQ_ASSERT_ALWAYS(a_full_status, !(out_valid_r && status_r == ST_FULL) || full, "full status with free room")
  `SMPQ_ASSERT_ALWAYS(a_empty_status, !(out_valid_r && status_r == ST_EMPTY) || empty, "empty status with stored items")

endmodule

[hw/rtl/smpq_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smpq_cell
// one slot of the sorted chain: holds a word, shifts toward tail on insert
// and toward head on remove
// ---------------------------------------------------------------------------
module smpq_cell
  import smpq_pkg::*;
(
  input  logic      clk,
  input  logic      is_head,
  input  logic      occupied,
  input  cell_cmd_t cmd,
  input  entry_t    new_entry,
  input  entry_t    prev_entry,
  input  logic      prev_flag,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      flag
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   lighter;
  logic   not_heavier;

  // new word belongs at or before this slot
  assign lighter     = $signed(new_entry.weight) <  $signed(entry_r.weight);
  assign not_heavier = $signed(new_entry.weight) <= $signed(entry_r.weight);
  assign flag        = !occupied || (is_head ? lighter : not_heavier);

  // slot update
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.insert) begin
      if (prev_flag) begin
        entry_nxt = prev_entry;
      end else if (flag) begin
        entry_nxt = new_entry;
      end
    end else if (cmd.remove) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[tb/sorted_min_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_min_priority_queue_unit_tb
// self-checking bench for the sorted min-priority queue. a driver pushes
// insert and remove words from a prepared list, a monitor checks every
// result against a cycle-free software copy of the queue. covers the empty
// and full corners, equal-weight ordering, extreme keys and heavy stalling.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue_unit_tb;
  import smpq_pkg::*;

  localparam int NUM_WORDS   = 1250;
  localparam int IDLE_LIMIT  = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 150;

  // one word offered on the input channel
  typedef struct {
    op_t                   op;
    logic [ID_W-1:0]       id;
    logic signed [WT_W-1:0] weight;
    int                    gap;
    bit                    wait_empty;
  } stim_word_t;

  // one expected result word
  typedef struct {
    status_t                status;
    logic [ID_W-1:0]        id;
    logic signed [WT_W-1:0] weight;
    logic [OCC_W-1:0]       occupancy;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_operation = 1'b0;
  logic [ID_W-1:0]        in_item_id = '0;
  logic signed [WT_W-1:0] in_item_weight = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_status;
  logic [ID_W-1:0]        out_id;
  logic signed [WT_W-1:0] out_weight;
  logic [OCC_W-1:0]       out_occupancy;

  sorted_min_priority_queue_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_item_id     (in_item_id),
    .in_item_weight (in_item_weight),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_weight     (out_weight),
    .out_occupancy  (out_occupancy)
  );

  stim_word_t    stim_words[$];
  queue_result_t expected_results[$];

  // software copy of the sorted queue
  logic [ID_W-1:0]        model_ids[CAPACITY];
  logic signed [WT_W-1:0] model_wts[CAPACITY];
  int                     model_count = 0;

  int words_sent = 0;
  int results_checked = 0;
  int error_count = 0;
  int full_drops = 0;
  int empty_pops = 0;
  int max_fill = 0;
  int plan_count = 0;
  int gap_left = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // apply one operation to the queue copy and return the result it gives
  function automatic queue_result_t apply_queue_op(op_t op, logic [ID_W-1:0] id,
                                                   logic signed [WT_W-1:0] w);
    queue_result_t res;
    int pos;
    res.status = ST_INSERTED;
    res.id     = '0;
    res.weight = '0;
    if (op == OP_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
        full_drops++;
      end else begin
        // head only on a strictly lighter key, else before first not-lighter
        if (model_count == 0 || w < model_wts[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < model_count && model_wts[pos] < w) pos++;
        end
        for (int k = model_count; k > pos; k--) begin
          model_ids[k] = model_ids[k-1];
          model_wts[k] = model_wts[k-1];
        end
        model_ids[pos] = id;
        model_wts[pos] = w;
        model_count++;
        if (model_count > max_fill) max_fill = model_count;
      end
    end else begin
      if (model_count == 0) begin
        res.status = ST_EMPTY;
        empty_pops++;
      end else begin
        res.status = ST_REMOVED;
        res.id     = model_ids[0];
        res.weight = model_wts[0];
        for (int k = 1; k < model_count; k++) begin
          model_ids[k-1] = model_ids[k];
          model_wts[k-1] = model_wts[k];
        end
        model_count--;
      end
    end
    res.occupancy = OCC_W'(model_count);
    return res;
  endfunction

  // key mix: extremes, a narrow band for ties, and full-range values
  function automatic logic signed [WT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4, 5: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // append one word to the stimulus list, tracking the planned fill level
  task automatic add_word(op_t op, logic [ID_W-1:0] id, logic signed [WT_W-1:0] w,
                          int gap, bit wait_empty);
    stim_word_t sw;
    sw.op         = op;
    sw.id         = id;
    sw.weight     = w;
    sw.gap        = gap;
    sw.wait_empty = wait_empty;
    stim_words.push_back(sw);
    if (op == OP_INSERT && plan_count < CAPACITY) plan_count++;
    if (op == OP_REMOVE && plan_count > 0) plan_count--;
  endtask

  // stimulus list, reset and end of run
  initial begin
    int  kind;
    int  n;
    bit  burst;
    bit  first_episode;
    bit  hold;
    op_t op;

    // directed: empty pop, extreme keys, ties at and after the head, ignored fields
    add_word(OP_REMOVE, 16'hffff, 32'sh7fffffff, 0, 1'b0);
    add_word(OP_INSERT, 16'h0000, 32'sd0, 0, 1'b0);
    add_word(OP_INSERT, 16'hffff, 32'sd0, 0, 1'b0);
    add_word(OP_INSERT, 16'h0001, 32'sh7fffffff, 0, 1'b0);
    add_word(OP_INSERT, 16'h0002, 32'sh80000000, 0, 1'b0);
    add_word(OP_INSERT, 16'h0003, -32'sd1, 0, 1'b0);
    add_word(OP_INSERT, 16'h0004, 32'sd0, 0, 1'b0);
    add_word(OP_INSERT, 16'h0005, 32'sh80000000, 0, 1'b0);
    add_word(OP_INSERT, 16'haaaa, 32'sh7fffffff, 0, 1'b0);
    add_word(OP_INSERT, 16'h5555, -32'sd1, 0, 1'b0);
    for (int i = 0; i < 11; i++) begin
      add_word(OP_REMOVE, 16'($urandom), $signed($urandom), 0, 1'b0);
    end

    // random episodes: fill to full, drain to empty, or a mixed run
    first_episode = 1'b1;
    while (stim_words.size() < NUM_WORDS) begin
      kind  = $urandom_range(0, 9);
      burst = ($urandom_range(0, 3) == 0);
      hold  = first_episode || ($urandom_range(0, 5) == 0);
      first_episode = 1'b0;
      if (kind < 2) n = CAPACITY - plan_count + $urandom_range(1, 3);
      else if (kind < 4) n = plan_count + $urandom_range(1, 2);
      else n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        if (kind < 2) op = OP_INSERT;
        else if (kind < 4) op = OP_REMOVE;
        else op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_REMOVE;
        add_word(op, 16'($urandom), rand_weight(), burst ? 0 : rand_gap(),
                 hold && i == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every word to go in and every result to come back
    @(negedge clk);
    while (stim_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d words driven, %0d results checked, peak fill %0d of %0d",
             words_sent, results_checked, max_fill, CAPACITY);
    $display("%0d inserts dropped on a full queue, %0d removes on an empty queue",
             full_drops, empty_pops);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: offer the next word after its gap, predict on acceptance
  always @(posedge clk) begin
    stim_word_t    nxt;
    queue_result_t res;
    logic          offer;
    int            sent_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer    = in_valid;
      sent_now = words_sent;
      if (in_valid && in_ready) begin
        res = apply_queue_op(op_t'(in_operation), in_item_id, in_item_weight);
        expected_results.push_back(res);
        sent_now = words_sent + 1;
        words_sent <= sent_now;
        offer = 1'b0;
        gap_left = (stim_words.size() > 0) ? stim_words[0].gap : 0;
      end
      if (!offer && stim_words.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(stim_words[0].wait_empty && sent_now != results_checked)) begin
          nxt = stim_words.pop_front();
          in_operation   <= nxt.op;
          in_item_id     <= nxt.id;
          in_item_weight <= nxt.weight;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // receiver ready: random stretches plus one long hold-off mid-run
  int  stretch_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    logic rdy;
    int   r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rdy = out_ready;
      if (!long_hold_done && words_sent >= 500) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stretch_left > 0) begin
        stretch_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rdy = 1'b1;
          stretch_left = $urandom_range(0, 19);
        end else if (r < 65) begin
          rdy = 1'b1;
          stretch_left = $urandom_range(40, 120);
        end else if (r < 92) begin
          rdy = 1'b0;
          stretch_left = $urandom_range(0, 2);
        end else begin
          rdy = 1'b0;
          stretch_left = $urandom_range(8, 30);
        end
      end
      out_ready <= rdy;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (error_count < 10)
          $display("ERROR: result with nothing pending: status %0d id %h weight %0d occ %0d",
                   out_status, out_id, out_weight, out_occupancy);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status || out_id !== exp_res.id ||
            out_weight !== exp_res.weight || out_occupancy !== exp_res.occupancy) begin
          if (error_count < 10) begin
            $display("ERROR: result %0d: exp status %0d id %h weight %0d occ %0d",
                     results_checked, exp_res.status, exp_res.id, exp_res.weight,
                     exp_res.occupancy);
            $display("       got status %0d id %h weight %0d occ %0d",
                     out_status, out_id, out_weight, out_occupancy);
          end
          error_count++;
        end
      end
      results_checked <= results_checked + 1;
    end
  end

  // watchdog: too long with no word moving on either channel, or too long in all
  int idle_cycles = 0;
  int total_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      total_cycles++;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT || total_cycles >= CYCLE_LIMIT) begin
        $display("ERROR: timeout after %0d cycles, %0d words in, %0d results out",
                 total_cycles, words_sent, results_checked);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
